// File: rtl/pdu_concatenation_sizer_defines.svh
// Assertion macros shared by the RTL files of the concatenation sizer.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef PDU_CONCATENATION_SIZER_DEFINES_SVH
`define PDU_CONCATENATION_SIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge.
`define PCS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define PCS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define PCS_ASSERT(name, prop, msg)
`define PCS_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// File: rtl/pcs_pkg.sv
`default_nettype none

package pcs_pkg;

  // Field and register widths
  localparam int ENTRY_W     = 16;
  localparam int TOTAL_W     = 20;
  localparam int COUNT_W     = 7;
  localparam int COUNT_LIMIT = 64;
  localparam int SUM_W       = 21;
  localparam int HDR_CFG_W   = 12;
  localparam int PAD_W       = 16;
  localparam int STATUS_W    = 3;

  // Derived datapath widths
  localparam int HPART_W = ENTRY_W + 1;
  localparam int DVD_W   = ENTRY_W + 2;
  localparam int ACC_W   = SUM_W + 1;
  localparam int FIT_W   = ACC_W + 2;

  // Remainder unit: radix-4, two quotient bits a step
  localparam int RADIX_BITS = 2;
  localparam int DIV_STEPS  = DVD_W / RADIX_BITS;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // Port widths
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int IN_DATA_W   = 2 * ENTRY_W;
  localparam int OUT_BITS    = COUNT_W + 2 * TOTAL_W + 2;
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Register reset values
  localparam logic [TOTAL_W-1:0]   MAX_SIZE_RST    = TOTAL_W'(12000);
  localparam logic [COUNT_W-1:0]   MAX_ENTRY_RST   = COUNT_W'(8);
  localparam logic [HDR_CFG_W-1:0] CONCAT_HDR_RST  = HDR_CFG_W'(8);
  localparam logic [HDR_CFG_W-1:0] PER_ENTRY_RST   = HDR_CFG_W'(16);
  localparam logic [HDR_CFG_W-1:0] SINGLE_XTRA_RST = HDR_CFG_W'(1);
  localparam logic                 COUNT_HDR_RST   = 1'b1;
  localparam logic [PAD_W-1:0]     PAD_RST         = PAD_W'(8);

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_SIZE    = 3'd0,
    CFG_MAX_ENTRY   = 3'd1,
    CFG_CONCAT_HDR  = 3'd2,
    CFG_PER_ENTRY   = 3'd3,
    CFG_SINGLE_XTRA = 3'd4,
    CFG_COUNT_HDR   = 3'd5,
    CFG_PAD         = 3'd6
  } cfg_reg_t;

  // Outcome of one request; the code is the result status
  typedef enum logic [STATUS_W-1:0] {
    OP_STARTED  = 3'd0,
    OP_ADDED    = 3'd1,
    OP_DEFERRED = 3'd2,
    OP_REFUSED  = 3'd3,
    OP_SENT     = 3'd4,
    OP_EMPTY    = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_FIRST,
    S_WAIT_FIRST,
    S_DIV_NEW,
    S_WAIT_NEW,
    S_CHECK,
    S_PRE_REPORT,
    S_APPLY,
    S_REPORT,
    S_OUT
  } fsm_state_t;

  // Controller to datapath
  typedef struct packed {
    logic cap;
    logic acc_init;
    logic div_start;
    logic sel_new;
    logic acc_add;
    logic apply;
    logic report;
    logic out_load;
    op_t  op;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_take;
    logic active;
    logic pending;
    logic count_le1;
    logic div_done;
    logic fits;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/pcs_mod.sv
`default_nettype none
`include "pdu_concatenation_sizer_defines.svh"

// Iterative remainder unit, restoring, two dividend bits a cycle.
module pcs_mod (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [pcs_pkg::DVD_W-1:0] dividend,
  input  wire logic [pcs_pkg::PAD_W-1:0] divisor,
  output logic      [pcs_pkg::PAD_W-1:0] rem,
  output logic                           done
);
  import pcs_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  dvd_nxt;
  logic [PAD_W-1:0]  dsr_r;
  logic [PAD_W:0]    rem_r;
  logic [PAD_W:0]    rem_nxt;

  // Shift in dividend bits, subtract the divisor where it fits
  always_comb begin
    logic [PAD_W:0]   r;
    logic [DVD_W-1:0] d;
    r = rem_r;
    d = dvd_r;
    for (int i = 0; i < RADIX_BITS; i++) begin
      r = {r[PAD_W-1:0], d[DVD_W-1]};
      d = {d[DVD_W-2:0], 1'b0};
      if (r >= {1'b0, dsr_r}) begin
        r = r - {1'b0, dsr_r};
      end
    end
    rem_nxt = r;
    dvd_nxt = d;
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rem  = rem_r[PAD_W-1:0];
  assign done = done_r;

  `PCS_ASSERT(a_start_idle, !(start && busy_r), "remainder unit restarted while busy")

endmodule

`default_nettype wire

// File: rtl/pcs_datapath.sv
`default_nettype none
`include "pdu_concatenation_sizer_defines.svh"

// Container state, size arithmetic, configuration and result register.
module pcs_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pcs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [pcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_command,
  input  wire logic [pcs_pkg::ENTRY_W-1:0]    in_header,
  input  wire logic [pcs_pkg::ENTRY_W-1:0]    in_payload,
  input  wire pcs_pkg::ctrl_cmd_t             cmd,
  output pcs_pkg::dp_stat_t                   stat,
  output logic [pcs_pkg::STATUS_W-1:0]        out_status,
  output logic [pcs_pkg::COUNT_W-1:0]         out_entries,
  output logic [pcs_pkg::TOTAL_W-1:0]         out_header,
  output logic [pcs_pkg::TOTAL_W-1:0]         out_payload,
  output logic                                out_has_capacity,
  output logic                                out_has_container
);
  import pcs_pkg::*;

  localparam logic [ACC_W-1:0] TOTAL_MAX = ACC_W'((1 << TOTAL_W) - 1);

  function automatic logic [TOTAL_W-1:0] sat_total(input logic [ACC_W-1:0] v);
    sat_total = (v > TOTAL_MAX) ? TOTAL_MAX[TOTAL_W-1:0] : v[TOTAL_W-1:0];
  endfunction

  // Configuration registers
  logic [TOTAL_W-1:0]   max_size_r;
  logic [COUNT_W-1:0]   max_entry_r;
  logic [HDR_CFG_W-1:0] concat_hdr_r;
  logic [HDR_CFG_W-1:0] per_entry_r;
  logic [HDR_CFG_W-1:0] single_xtra_r;
  logic                 count_hdr_r;
  logic [PAD_W-1:0]     pad_r;

  // Container state
  logic                 active_r;
  logic [COUNT_W-1:0]   count_r;
  logic [SUM_W-1:0]     multi_hdr_r;
  logic [SUM_W-1:0]     multi_pay_r;
  logic [ENTRY_W-1:0]   first_hdr_r;
  logic [ENTRY_W-1:0]   first_pay_r;
  logic                 pend_r;
  logic [ENTRY_W-1:0]   next_hdr_r;
  logic [ENTRY_W-1:0]   next_pay_r;

  // Captured request, accumulators, report and result
  logic                 cmd_r;
  logic [ENTRY_W-1:0]   req_hdr_r;
  logic [ENTRY_W-1:0]   req_pay_r;
  logic [ACC_W-1:0]     acc_hdr_r;
  logic [ACC_W-1:0]     acc_pay_r;
  logic [COUNT_W-1:0]   res_entries_r;
  logic [TOTAL_W-1:0]   res_hdr_r;
  logic [TOTAL_W-1:0]   res_pay_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [COUNT_W-1:0]   out_entries_r;
  logic [TOTAL_W-1:0]   out_hdr_r;
  logic [TOTAL_W-1:0]   out_pay_r;
  logic                 out_cap_r;
  logic                 out_cont_r;

  // Per-entry arithmetic
  logic [ENTRY_W-1:0]   ent_hdr;
  logic [ENTRY_W-1:0]   ent_pay;
  logic [HPART_W-1:0]   hpart;
  logic [HPART_W-1:0]   ppart;
  logic [DVD_W-1:0]     dividend;
  logic [PAD_W-1:0]     boundary;
  logic [PAD_W-1:0]     rem;
  logic [PAD_W-1:0]     pad_fill;
  logic                 div_done;
  logic [FIT_W-1:0]     total;
  logic [COUNT_W-1:0]   limit;
  logic [COUNT_W:0]     count_inc;
  logic [ACC_W-1:0]     hdr_single;
  logic [ACC_W-1:0]     hdr_multi;

  // Select the entry being sized and form its header part and padded payload
  always_comb begin
    ent_hdr  = cmd.sel_new ? req_hdr_r : first_hdr_r;
    ent_pay  = cmd.sel_new ? req_pay_r : first_pay_r;
    hpart    = count_hdr_r ? (HPART_W'(ent_hdr) + HPART_W'(per_entry_r))
                           : HPART_W'(per_entry_r);
    dividend = DVD_W'(ent_pay) + DVD_W'(hpart);
    boundary = (pad_r == '0) ? PAD_W'(1) : pad_r;
    pad_fill = (rem == '0) ? '0 : (boundary - rem);
    ppart    = HPART_W'(ent_pay) + HPART_W'(pad_fill);
  end

  pcs_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (boundary),
    .rem      (rem),
    .done     (div_done)
  );

  // Size and entry limit check of the grown container
  always_comb begin
    total     = FIT_W'(concat_hdr_r) + FIT_W'(acc_hdr_r) + FIT_W'(acc_pay_r);
    limit     = (max_entry_r > COUNT_W'(COUNT_LIMIT)) ? COUNT_W'(COUNT_LIMIT) : max_entry_r;
    count_inc = {1'b0, count_r} + (COUNT_W + 1)'(1);
  end

  // Report arithmetic of the current container
  always_comb begin
    hdr_single = ACC_W'(first_hdr_r) + ACC_W'(single_xtra_r);
    hdr_multi  = ACC_W'(concat_hdr_r) + ACC_W'(multi_hdr_r);
  end

  always_comb begin
    stat.is_take   = cmd_r;
    stat.active    = active_r;
    stat.pending   = pend_r;
    stat.count_le1 = (count_r <= COUNT_W'(1));
    stat.div_done  = div_done;
    stat.fits      = (total <= FIT_W'(max_size_r)) && (count_inc <= {1'b0, limit});
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r    <= MAX_SIZE_RST;
      max_entry_r   <= MAX_ENTRY_RST;
      concat_hdr_r  <= CONCAT_HDR_RST;
      per_entry_r   <= PER_ENTRY_RST;
      single_xtra_r <= SINGLE_XTRA_RST;
      count_hdr_r   <= COUNT_HDR_RST;
      pad_r         <= PAD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MAX_SIZE:    max_size_r    <= cfg_wdata[TOTAL_W-1:0];
        CFG_MAX_ENTRY:   max_entry_r   <= cfg_wdata[COUNT_W-1:0];
        CFG_CONCAT_HDR:  concat_hdr_r  <= cfg_wdata[HDR_CFG_W-1:0];
        CFG_PER_ENTRY:   per_entry_r   <= cfg_wdata[HDR_CFG_W-1:0];
        CFG_SINGLE_XTRA: single_xtra_r <= cfg_wdata[HDR_CFG_W-1:0];
        CFG_COUNT_HDR:   count_hdr_r   <= cfg_wdata[0];
        CFG_PAD:         pad_r         <= cfg_wdata[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Apply the outcome of a request to the container state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      count_r     <= '0;
      multi_hdr_r <= '0;
      multi_pay_r <= '0;
      first_hdr_r <= '0;
      first_pay_r <= '0;
      pend_r      <= 1'b0;
      next_hdr_r  <= '0;
      next_pay_r  <= '0;
    end else if (cmd.apply) begin
      case (cmd.op)
        OP_STARTED: begin
          active_r    <= 1'b1;
          count_r     <= COUNT_W'(1);
          first_hdr_r <= req_hdr_r;
          first_pay_r <= req_pay_r;
          multi_hdr_r <= '0;
          multi_pay_r <= '0;
        end
        OP_ADDED: begin
          count_r     <= count_inc[COUNT_W-1:0];
          multi_hdr_r <= acc_hdr_r[SUM_W-1:0];
          multi_pay_r <= acc_pay_r[SUM_W-1:0];
        end
        OP_DEFERRED: begin
          pend_r     <= 1'b1;
          next_hdr_r <= req_hdr_r;
          next_pay_r <= req_pay_r;
        end
        OP_SENT: begin
          // Promote the pending container, or close out
          active_r    <= pend_r;
          count_r     <= pend_r ? COUNT_W'(1) : '0;
          first_hdr_r <= pend_r ? next_hdr_r : '0;
          first_pay_r <= pend_r ? next_pay_r : '0;
          multi_hdr_r <= '0;
          multi_pay_r <= '0;
          pend_r      <= 1'b0;
          next_hdr_r  <= '0;
          next_pay_r  <= '0;
        end
        default: ;
      endcase
    end
  end

  // Request capture, accumulators, report and result registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cmd_r     <= in_command;
      req_hdr_r <= in_header;
      req_pay_r <= in_payload;
    end
    if (cmd.acc_init) begin
      acc_hdr_r <= stat.count_le1 ? '0 : ACC_W'(multi_hdr_r);
      acc_pay_r <= stat.count_le1 ? '0 : ACC_W'(multi_pay_r);
    end else if (cmd.acc_add) begin
      acc_hdr_r <= acc_hdr_r + ACC_W'(hpart);
      acc_pay_r <= acc_pay_r + ACC_W'(ppart);
    end
    if (cmd.report) begin
      if (!active_r) begin
        res_entries_r <= '0;
        res_hdr_r     <= '0;
        res_pay_r     <= '0;
      end else if (stat.count_le1) begin
        res_entries_r <= count_r;
        res_hdr_r     <= sat_total(hdr_single);
        res_pay_r     <= sat_total(ACC_W'(first_pay_r));
      end else begin
        res_entries_r <= count_r;
        res_hdr_r     <= sat_total(hdr_multi);
        res_pay_r     <= sat_total(ACC_W'(multi_pay_r));
      end
    end
    if (cmd.out_load) begin
      out_status_r  <= cmd.op;
      out_entries_r <= res_entries_r;
      out_hdr_r     <= res_hdr_r;
      out_pay_r     <= res_pay_r;
      out_cap_r     <= !pend_r && (count_r <= max_entry_r);
      out_cont_r    <= active_r;
    end
  end

  assign out_status        = out_status_r;
  assign out_entries       = out_entries_r;
  assign out_header        = out_hdr_r;
  assign out_payload       = out_pay_r;
  assign out_has_capacity  = out_cap_r;
  assign out_has_container = out_cont_r;

  `PCS_ASSERT(a_pend_needs_active, !pend_r || active_r, "pending container without current one")
  `PCS_ASSERT(a_count_active, (active_r == (count_r != '0)) && (count_r <= COUNT_W'(COUNT_LIMIT)), "entry count out of step with container")

endmodule

`default_nettype wire

// File: rtl/pcs_ctrl.sv
`default_nettype none
`include "pdu_concatenation_sizer_defines.svh"

// Request sequencer: decodes a request, runs the sizing steps, hands off the result.
module pcs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire pcs_pkg::dp_stat_t stat,
  output pcs_pkg::ctrl_cmd_t     cmd
);
  import pcs_pkg::*;

  fsm_state_t state_r;
  fsm_state_t state_nxt;
  op_t        op_r;
  op_t        op_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.op        = op_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_take) begin
          if (stat.active) begin
            op_nxt    = OP_SENT;
            state_nxt = S_PRE_REPORT;
          end else begin
            op_nxt    = OP_EMPTY;
            state_nxt = S_REPORT;
          end
        end else if (!stat.active) begin
          op_nxt    = OP_STARTED;
          state_nxt = S_APPLY;
        end else if (stat.pending) begin
          op_nxt    = OP_REFUSED;
          state_nxt = S_REPORT;
        end else begin
          cmd.acc_init = 1'b1;
          state_nxt    = stat.count_le1 ? S_DIV_FIRST : S_DIV_NEW;
        end
      end
      S_DIV_FIRST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT_FIRST;
      end
      S_WAIT_FIRST: begin
        if (stat.div_done) begin
          cmd.acc_add = 1'b1;
          state_nxt   = S_DIV_NEW;
        end
      end
      S_DIV_NEW: begin
        cmd.sel_new   = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT_NEW;
      end
      S_WAIT_NEW: begin
        cmd.sel_new = 1'b1;
        if (stat.div_done) begin
          cmd.acc_add = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        op_nxt    = stat.fits ? OP_ADDED : OP_DEFERRED;
        state_nxt = S_APPLY;
      end
      S_PRE_REPORT: begin
        cmd.report = 1'b1;
        state_nxt  = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = (op_r == OP_SENT) ? S_OUT : S_REPORT;
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        // Hold until the result register is free
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid: set on load, drop when taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  `PCS_ASSERT(a_no_overwrite, !cmd.out_load || !out_valid_r || out_tready, "result overwritten before it was taken")
  `PCS_ASSERT_NEXT(a_accept_decode, in_tvalid && in_tready, state_r == S_DECODE, "accepted request not decoded")

endmodule

`default_nettype wire

// File: rtl/pdu_concatenation_sizer.sv
// A refused add or an empty take runs decode, report and output; a start decode, apply, report
// and output; a take decode, report, apply and output. An add sizes the new entry, checks the
// fit, applies and reports; the add that makes the second entry sizes both. Each sizing runs
// the radix-4 remainder unit for 9 steps. One request is in flight at a time; the next one is
// taken as soon as the result sits in the output register, even before it is read. Reset
// (rst_n low, synchronous) empties the container and restores register defaults.
`default_nettype none

module pdu_concatenation_sizer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [pcs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [pcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // entry_header_bits[15:0], entry_payload_bits[31:16]
  input  wire logic [pcs_pkg::IN_DATA_W-1:0]  in_tdata,
  // command[0]
  input  wire logic                           in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // container_entries[6:0], container_header_bits[26:7], container_payload_bits[46:27],
  // has_capacity[47], has_container[48], zero fill[55:49]
  output logic [pcs_pkg::OUT_DATA_W-1:0]      out_tdata,
  // status[2:0]
  output logic [pcs_pkg::STATUS_W-1:0]        out_tuser
);
  import pcs_pkg::*;

  ctrl_cmd_t          cmd;
  dp_stat_t           stat;
  logic [COUNT_W-1:0] res_entries;
  logic [TOTAL_W-1:0] res_hdr;
  logic [TOTAL_W-1:0] res_pay;
  logic               res_cap;
  logic               res_cont;

  pcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pcs_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_command        (in_tuser),
    .in_header         (in_tdata[ENTRY_W-1:0]),
    .in_payload        (in_tdata[2*ENTRY_W-1:ENTRY_W]),
    .cmd               (cmd),
    .stat              (stat),
    .out_status        (out_tuser),
    .out_entries       (res_entries),
    .out_header        (res_hdr),
    .out_payload       (res_pay),
    .out_has_capacity  (res_cap),
    .out_has_container (res_cont)
  );

  // Pack the result fields, lowest first
  assign out_tdata = {(OUT_DATA_W - OUT_BITS)'(0), res_cont, res_cap, res_pay, res_hdr,
                      res_entries};

endmodule

`default_nettype wire
